>>> src/user_event_queue_macros.svh
// Assertion macros shared by the user event queue RTL.
// Needs nothing else; included inside module bodies.
`ifndef USER_EVENT_QUEUE_MACROS_SVH
`define USER_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define UEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("label failed");

// Next-cycle implication, checked out of reset.
`define UEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("label failed");

`endif

>>> src/ueq_pkg.sv
// Shared constants of the user event queue: opcodes, status codes, defaults.
// No dependencies.
package ueq_pkg;
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MAX_POLL_DEF      = 16;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_TRIG = 2'd2;
    localparam logic [1:0] OP_POLL = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOENT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef logic [63:0] t_word;
endpackage

>>> src/ueq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ueq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/user_event_queue.sv
// User event queue: registration table, ordered pending list, sequencer.
// Depends on ueq_pkg, ueq_ram and user_event_queue_macros.svh.
//
// A request is taken when start is high and busy is low. Add, delete and
// trigger each give one result; a poll gives one result per event returned,
// or a single empty result, with o_last on the final one. Every result is on
// the o_ ports for exactly one cycle, marked by o_valid; the receiver cannot
// stall them.
// Timing is set by the single compare path, which walks the RAM one entry at
// a time, reading it and then comparing. Add, delete and trigger search the
// table entry by entry, and delete and trigger then search the pending list
// the same way; a delete also shifts the entries behind the removed one, each
// read and then written back. A poll reads and emits one event at a time. An
// empty poll answers straight from idle. The last result is on the outputs in
// the first cycle in which busy is low again.
// Synchronous reset clears the registrations and empties the pending list;
// table and list contents are not cleared, as they are only read once written.
module user_event_queue #(
    parameter int TABLE_ENTRIES = ueq_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_POLL      = ueq_pkg::MAX_POLL_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_opcode,
    input  ueq_pkg::t_word      i_ident,
    input  logic                i_edge_mode,
    input  ueq_pkg::t_word      i_user_data,
    input  logic [4:0]          i_max_count,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic                o_has_event,
    output ueq_pkg::t_word      o_event_ident,
    output logic                o_event_edge,
    output ueq_pkg::t_word      o_event_data,
    output logic                o_last
);
    import ueq_pkg::*;
    `include "user_event_queue_macros.svh"

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int LW = (CW > 7) ? CW : 7;
    localparam int RW = 65;
    localparam int PW = 129;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RRD  = 4'd1;
    localparam logic [3:0] S_RCMP = 4'd2;
    localparam logic [3:0] S_PRD  = 4'd3;
    localparam logic [3:0] S_PCMP = 4'd4;
    localparam logic [3:0] S_SRD  = 4'd5;
    localparam logic [3:0] S_SWR  = 4'd6;
    localparam logic [3:0] S_ORD  = 4'd7;
    localparam logic [3:0] S_OEMIT = 4'd8;

    logic [3:0]             r_state, n_state;
    logic [1:0]             r_op, n_op;
    t_word                  r_id, n_id;
    logic                   r_edge, n_edge;
    t_word                  r_data, n_data;
    logic [IW-1:0]          r_idx, n_idx;
    logic [IW-1:0]          r_free, n_free;
    logic                   r_free_ok, n_free_ok;
    logic                   r_hedge, n_hedge;
    logic [TABLE_ENTRIES-1:0] r_vbits, n_vbits;
    logic [IW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_j, n_j;
    logic [CW-1:0]          r_left, n_left;
    logic                   r_o_valid, n_o_valid;
    logic [1:0]             r_o_status, n_o_status;
    logic                   r_o_has, n_o_has;
    t_word                  r_o_ident, n_o_ident;
    logic                   r_o_edge, n_o_edge;
    t_word                  r_o_data, n_o_data;
    logic                   r_o_last, n_o_last;

    logic                   reg_we;
    logic [IW-1:0]          reg_waddr, reg_raddr;
    logic [RW-1:0]          reg_wdata, reg_rdata;
    logic                   pend_we;
    logic [IW-1:0]          pend_waddr, pend_raddr;
    logic [PW-1:0]          pend_wdata, pend_rdata;

    logic                   fin;
    logic [1:0]             fin_st;
    logic                   pmiss;
    logic                   hit;
    logic [IW-1:0]          fslot;
    logic                   fslot_ok;
    logic [LW-1:0]          pc_a, pc_b;

    // Position of list entry j in the circular buffer.
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                           input logic [CW-1:0] j);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(j);
        if (s >= (CW+1)'(TABLE_ENTRIES)) begin
            s = s - (CW+1)'(TABLE_ENTRIES);
        end
        return s[IW-1:0];
    endfunction

    ueq_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES), .AW(IW)) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_waddr (reg_waddr),
        .i_wdata (reg_wdata),
        .i_raddr (reg_raddr),
        .o_rdata (reg_rdata)
    );

    ueq_ram #(.WIDTH(PW), .DEPTH(TABLE_ENTRIES), .AW(IW)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (pend_wdata),
        .i_raddr (pend_raddr),
        .o_rdata (pend_rdata)
    );

    always_comb begin
        n_state = r_state;   n_op = r_op;       n_id = r_id;
        n_edge = r_edge;     n_data = r_data;   n_idx = r_idx;
        n_free = r_free;     n_free_ok = r_free_ok;
        n_hedge = r_hedge;   n_vbits = r_vbits; n_head = r_head;
        n_count = r_count;   n_j = r_j;         n_left = r_left;
        n_o_valid = 1'b0;    n_o_status = r_o_status; n_o_has = r_o_has;
        n_o_ident = r_o_ident; n_o_edge = r_o_edge;
        n_o_data = r_o_data; n_o_last = r_o_last;
        reg_we = 1'b0;  reg_waddr = r_idx;  reg_raddr = r_idx;
        reg_wdata = {r_edge, r_id};
        pend_we = 1'b0; pend_waddr = phys(r_head, r_j);
        pend_raddr = phys(r_head, r_j);
        pend_wdata = {r_hedge, r_id, r_data};
        fin = 1'b0; fin_st = ST_OK; pmiss = 1'b0;
        hit = r_vbits[r_idx] && (reg_rdata[63:0] == r_id);
        fslot = r_free_ok ? r_free : r_idx;
        fslot_ok = r_free_ok || !r_vbits[r_idx];
        pc_a = (LW'(i_max_count) < LW'(r_count)) ? LW'(i_max_count) : LW'(r_count);
        pc_b = (pc_a < LW'(MAX_POLL)) ? pc_a : LW'(MAX_POLL);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op = i_opcode;  n_id = i_ident;  n_edge = i_edge_mode;
                    n_data = i_user_data;
                    n_idx = '0;  n_free_ok = 1'b0;  n_j = '0;
                    if (i_opcode == OP_POLL) begin
                        n_left = pc_b[CW-1:0];
                        if (pc_b == '0) begin
                            fin = 1'b1;
                        end else begin
                            n_state = S_ORD;
                        end
                    end else begin
                        n_state = S_RRD;
                    end
                end
            end
            S_RRD: begin
                n_state = S_RCMP;
            end
            S_RCMP: begin
                if (hit) begin
                    n_hedge = reg_rdata[64];
                    if (r_op == OP_ADD) begin
                        fin = 1'b1;
                    end else begin
                        if (r_op == OP_DEL) begin
                            n_vbits[r_idx] = 1'b0;
                        end
                        if (r_count == '0) begin
                            pmiss = 1'b1;
                        end else begin
                            n_state = S_PRD;
                        end
                    end
                end else begin
                    n_free = fslot;
                    n_free_ok = fslot_ok;
                    if (r_idx == IW'(TABLE_ENTRIES - 1)) begin
                        fin = 1'b1;
                        if (r_op == OP_ADD) begin
                            if (fslot_ok) begin
                                reg_we = 1'b1;
                                reg_waddr = fslot;
                                n_vbits[fslot] = 1'b1;
                            end else begin
                                fin_st = ST_FULL;
                            end
                        end else begin
                            fin_st = ST_NOENT;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_state = S_RRD;
                    end
                end
            end
            S_PRD: begin
                n_state = S_PCMP;
            end
            S_PCMP: begin
                if (pend_rdata[127:64] == r_id) begin
                    if (r_op == OP_DEL) begin
                        if (r_j + 1'b1 < r_count) begin
                            n_state = S_SRD;
                        end else begin
                            n_count = r_count - 1'b1;
                            fin = 1'b1;
                        end
                    end else begin
                        pend_we = 1'b1;
                        fin = 1'b1;
                    end
                end else if (r_j + 1'b1 == r_count) begin
                    pmiss = 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                    n_state = S_PRD;
                end
            end
            S_SRD: begin
                pend_raddr = phys(r_head, r_j + 1'b1);
                n_state = S_SWR;
            end
            S_SWR: begin
                // Close the gap: entry j+1 moves down to j.
                pend_we = 1'b1;
                pend_wdata = pend_rdata;
                n_j = r_j + 1'b1;
                if ((CW+1)'(r_j) + (CW+1)'(2) < (CW+1)'(r_count)) begin
                    n_state = S_SRD;
                end else begin
                    n_count = r_count - 1'b1;
                    fin = 1'b1;
                end
            end
            S_ORD: begin
                pend_raddr = r_head;
                n_state = S_OEMIT;
            end
            S_OEMIT: begin
                n_o_valid = 1'b1;  n_o_status = ST_OK;  n_o_has = 1'b1;
                n_o_ident = pend_rdata[127:64];
                n_o_edge = pend_rdata[128];
                n_o_data = pend_rdata[63:0];
                n_o_last = (r_left == CW'(1));
                n_head = (r_head == IW'(TABLE_ENTRIES - 1)) ? '0 : r_head + 1'b1;
                // A level entry goes straight back to the tail, so the
                // count is unchanged; an edge entry leaves the list.
                if (pend_rdata[128]) begin
                    n_count = r_count - 1'b1;
                end else begin
                    pend_we = 1'b1;
                    pend_waddr = phys(r_head, r_count);
                    pend_wdata = pend_rdata;
                end
                n_left = r_left - 1'b1;
                n_state = (r_left == CW'(1)) ? S_IDLE : S_ORD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (pmiss) begin
            fin = 1'b1;
            if (r_op == OP_TRIG) begin
                if (r_count >= CW'(TABLE_ENTRIES)) begin
                    fin_st = ST_FULL;
                end else begin
                    // The edge flag may have been fetched in this very cycle.
                    pend_we = 1'b1;
                    pend_waddr = phys(r_head, r_count);
                    pend_wdata = {n_hedge, r_id, r_data};
                    n_count = r_count + 1'b1;
                end
            end
        end

        if (fin) begin
            n_o_valid = 1'b1;  n_o_status = fin_st;  n_o_has = 1'b0;
            n_o_ident = '0;    n_o_edge = 1'b0;      n_o_data = '0;
            n_o_last = 1'b1;   n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vbits <= '0;
            r_head <= '0;
            r_count <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vbits <= n_vbits;
            r_head <= n_head;
            r_count <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_op <= n_op;         r_id <= n_id;       r_edge <= n_edge;
        r_data <= n_data;     r_idx <= n_idx;     r_free <= n_free;
        r_free_ok <= n_free_ok; r_hedge <= n_hedge;
        r_j <= n_j;           r_left <= n_left;
        r_o_status <= n_o_status; r_o_has <= n_o_has;
        r_o_ident <= n_o_ident;   r_o_edge <= n_o_edge;
        r_o_data <= n_o_data;     r_o_last <= n_o_last;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_has_event   = r_o_has;
    assign o_event_ident = r_o_ident;
    assign o_event_edge  = r_o_edge;
    assign o_event_data  = r_o_data;
    assign o_last        = r_o_last;

    `UEQ_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy || o_valid)
    `UEQ_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_ENTRIES))
    `UEQ_ASSERT_NOW(a_midpoll_busy, i_clk, i_rst_n, o_valid && !o_last, busy)
    `UEQ_ASSERT_NOW(a_empty_last, i_clk, i_rst_n, o_valid && !o_has_event, o_last)
endmodule
